// ----- rtl/manchester_edge_decoder_top_defines.svh -----
// ----------------------------------------------------------------------------
// manchester edge decoder assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MANCHESTER_EDGE_DECODER_TOP_DEFINES_SVH
`define MANCHESTER_EDGE_DECODER_TOP_DEFINES_SVH

// checked only outside reset
`define MED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked in every cycle, reset included
`define MED_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/med_pkg.sv -----
// ----------------------------------------------------------------------------
// manchester edge decoder package
// stream widths, function codes and framing types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package med_pkg;

    localparam int TIME_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // tdata bit positions
    localparam int RISING_LSB = 0;
    localparam int TIME_LSB   = 1;

    // tuser codes
    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_IDLE = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0]  shift;
        logic [COUNT_W-1:0] count;
    } frame_t;

    typedef struct packed {
        frame_t            frame;
        logic              done;
        logic [BYTE_W-1:0] data;
    } push_t;

endpackage

`default_nettype wire

// ----- rtl/manchester_edge_decoder_top.sv -----
// ----------------------------------------------------------------------------
// manchester edge decoder
// decodes a manchester line from timestamped edge and idle-check items
// ----------------------------------------------------------------------------
// One item is taken per clock cycle when the result side is not stalled; the
// edge that completes a byte is held in the input register, and the decoded
// byte is then presented from the output register. An item is captured in an
// input register, the whole edge decision (gap against two thirds of the
// learned bit period, with both sides scaled by three so no divider is needed)
// is combinational, and the byte lands in an output register. The first edge
// marks a start time and the next edge at a different stamp sets the period.
// An idle check with more than five periods since the last edge clears the
// byte framing. Timestamps wrap modulo 2^STAMP_BITS.
`timescale 1ns / 1ps
`default_nettype none

module manchester_edge_decoder_top #(
    parameter int STAMP_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [med_pkg::S_TDATA_W-1:0] s_tdata,  // rising, time_us[31:0], zero pad
    input  logic                          s_tuser,  // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [med_pkg::M_TDATA_W-1:0] m_tdata   // data_byte
);
    import med_pkg::*;

    localparam int EXT_W = (STAMP_BITS > TIME_W) ? STAMP_BITS : TIME_W;
    localparam int CMP_W = STAMP_BITS + 3;

    // input register
    logic              in_valid_reg;
    logic              in_func_reg;
    logic              in_rising_reg;
    logic [TIME_W-1:0] in_time_reg;

    // decoder state
    logic                  awaiting_reg, awaiting_next;
    logic [STAMP_BITS-1:0] start_reg, start_next;
    logic [STAMP_BITS-1:0] period_reg, period_next;
    logic                  sync_reg, sync_next;
    logic                  prev_rising_reg, prev_rising_next;
    logic [STAMP_BITS-1:0] prev_gap_reg, prev_gap_next;
    logic                  prev_valid_reg, prev_valid_next;
    frame_t                frame_reg, frame_next;
    logic [STAMP_BITS-1:0] last_edge_reg, last_edge_next;
    logic [STAMP_BITS-1:0] last_act_reg, last_act_next;

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;

    logic                  advance;
    logic [EXT_W-1:0]      t_ext;
    logic [STAMP_BITS-1:0] t;
    logic                  learn;
    logic [STAMP_BITS-1:0] period_eff;
    logic [STAMP_BITS-1:0] gap;
    logic [STAMP_BITS-1:0] elapsed;
    logic [CMP_W-1:0]      gap3;
    logic [CMP_W-1:0]      thr2;
    logic [CMP_W-1:0]      five_p;
    logic                  gap_gt;
    logic                  gap_lt;
    logic                  idle_hit;
    logic                  emit;
    logic [BYTE_W-1:0]     emit_data;
    frame_t                frame_mid;
    push_t                 push_a;
    push_t                 push_b;

    function automatic push_t push_bit(frame_t f, logic b);
        push_t             r;
        logic [BYTE_W-1:0] v;
        v = f.shift | (BYTE_W'(b) << f.count);
        r.data = v;
        if (f.count == '1) begin
            r.frame = '0;
            r.done  = 1'b1;
        end else begin
            r.frame.shift = v;
            r.frame.count = f.count + COUNT_W'(1);
            r.done        = 1'b0;
        end
        return r;
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign t_ext      = EXT_W'(in_time_reg);
    assign t          = t_ext[STAMP_BITS-1:0];
    assign learn      = !awaiting_reg && (period_reg == '0);
    assign period_eff = learn ? (t - start_reg) : period_reg;
    assign gap        = t - last_edge_reg;
    assign elapsed    = t - last_act_reg;

    // gap > floor(2p/3) iff 3*gap > 2p, gap < floor(2p/3) iff 3*gap + 3 <= 2p
    assign gap3     = CMP_W'({gap, 1'b0}) + CMP_W'(gap);
    assign thr2     = CMP_W'({period_eff, 1'b0});
    assign gap_gt   = gap3 > thr2;
    assign gap_lt   = (gap3 + CMP_W'(3)) <= thr2;
    assign five_p   = CMP_W'({period_reg, 2'b00}) + CMP_W'(period_reg);
    assign idle_hit = (period_reg != '0) && (CMP_W'(elapsed) > five_p);

    always_comb begin
        awaiting_next    = awaiting_reg;
        start_next       = start_reg;
        period_next      = period_reg;
        sync_next        = sync_reg;
        prev_rising_next = prev_rising_reg;
        prev_gap_next    = prev_gap_reg;
        prev_valid_next  = prev_valid_reg;
        frame_next       = frame_reg;
        last_edge_next   = last_edge_reg;
        last_act_next    = last_act_reg;
        emit             = 1'b0;
        emit_data        = '0;
        frame_mid        = frame_reg;
        push_a           = push_bit(frame_reg, prev_rising_reg);
        push_b           = push_bit(frame_reg, in_rising_reg);

        if (advance) begin
            if (in_func_reg == FUNC_IDLE) begin
                if (idle_hit) begin
                    frame_next      = '0;
                    sync_next       = 1'b1;
                    prev_gap_next   = '0;
                    prev_valid_next = 1'b0;
                    last_edge_next  = '0;
                end
            end else begin
                awaiting_next = 1'b0;
                if (awaiting_reg) begin
                    start_next = t;
                end else if (learn) begin
                    period_next = period_eff;
                end

                if (sync_reg && (prev_gap_reg != '0)) begin
                    // resync edge: the earlier edge may carry a bit too
                    if (gap_gt) begin
                        frame_mid = push_a.frame;
                        if (push_a.done) begin
                            emit      = 1'b1;
                            emit_data = push_a.data;
                        end
                    end
                    push_b     = push_bit(frame_mid, in_rising_reg);
                    frame_next = push_b.frame;
                    if (push_b.done) begin
                        emit      = 1'b1;
                        emit_data = push_b.data;
                    end
                    prev_valid_next = 1'b1;
                    sync_next       = 1'b0;
                end else if (prev_valid_reg) begin
                    if (gap_gt) begin
                        frame_next = push_b.frame;
                        emit       = push_b.done;
                        emit_data  = push_b.data;
                    end else begin
                        prev_valid_next = 1'b0;
                    end
                end else if (gap_lt) begin
                    frame_next      = push_b.frame;
                    emit            = push_b.done;
                    emit_data       = push_b.data;
                    prev_valid_next = 1'b1;
                end

                prev_rising_next = in_rising_reg;
                prev_gap_next    = gap;
                last_edge_next   = t;
                last_act_next    = t;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            awaiting_reg    <= 1'b1;
            start_reg       <= '0;
            period_reg      <= '0;
            sync_reg        <= 1'b1;
            prev_rising_reg <= 1'b0;
            prev_gap_reg    <= '0;
            prev_valid_reg  <= 1'b0;
            frame_reg       <= '0;
            last_edge_reg   <= '0;
            last_act_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            awaiting_reg    <= awaiting_next;
            start_reg       <= start_next;
            period_reg      <= period_next;
            sync_reg        <= sync_next;
            prev_rising_reg <= prev_rising_next;
            prev_gap_reg    <= prev_gap_next;
            prev_valid_reg  <= prev_valid_next;
            frame_reg       <= frame_next;
            last_edge_reg   <= last_edge_next;
            last_act_reg    <= last_act_next;
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg   <= s_tuser;
            in_rising_reg <= s_tdata[RISING_LSB];
            in_time_reg   <= s_tdata[TIME_LSB +: TIME_W];
        end
        if (advance && emit) begin
            out_data_reg <= emit_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/med_checker.sv -----
// ----------------------------------------------------------------------------
// manchester edge decoder port checker
// watches the stream ports of the decoder top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "manchester_edge_decoder_top_defines.svh"

module med_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [med_pkg::M_TDATA_W-1:0] m_tdata
);

    `MED_ASSERT_ALWAYS(a_reset_clears_out, !aresetn |=> !m_tvalid, "result valid after reset")

    `MED_ASSERT(a_out_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled transfer changed")

    `MED_ASSERT(a_stall_cause, !s_tready |-> m_tvalid && !m_tready, "input stalled without result backpressure")

endmodule

bind manchester_edge_decoder_top med_checker u_med_checker (.*);

`default_nettype wire

// ----- verif/manchester_edge_decoder_checker.sv -----
// ----------------------------------------------------------------------------
// manchester edge decoder checker
// watches both stream channels, tracks the line framing of every accepted
// edge or idle-check transfer and compares each decoded byte with the oldest
// byte that the framing predicts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module manchester_edge_decoder_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [med_pkg::S_TDATA_W-1:0] s_tdata,  // rising, time_us[31:0], zero pad
    input  logic                          s_tuser,  // func
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [med_pkg::M_TDATA_W-1:0] m_tdata,  // data_byte
    output int                            errors,
    output int                            pending,
    output int                            results
);
    import med_pkg::*;

    localparam logic [TIME_W-1:0] STAMP_MAX = '1;

    logic              first_wait;
    logic [TIME_W-1:0] start_stamp;
    logic [TIME_W-1:0] period;
    logic              sync_wait;
    logic              last_dir;
    logic [TIME_W-1:0] last_gap;
    logic              data_edge;
    logic [BYTE_W-1:0] acc_byte;
    logic [2:0]        acc_count;
    logic [TIME_W-1:0] edge_stamp;
    logic [TIME_W-1:0] active_stamp;
    logic [BYTE_W-1:0] expected_bytes[$];
    logic [BYTE_W-1:0] want;

    function automatic logic [TIME_W-1:0] two_thirds_of(input logic [TIME_W-1:0] p);
        return 2 * (p / 3) + ((p % 3 == 2) ? 1 : 0);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_framing();
        acc_byte   = '0;
        acc_count  = '0;
        sync_wait  = 1'b1;
        last_gap   = '0;
        data_edge  = 1'b0;
        edge_stamp = '0;
    endtask

    task automatic shift_in(input logic b, inout logic done, inout logic [BYTE_W-1:0] byte_out);
        acc_byte = acc_byte | (BYTE_W'(b) << acc_count);
        if (acc_count == 3'd7) begin
            done      = 1'b1;
            byte_out  = acc_byte;
            acc_byte  = '0;
            acc_count = '0;
        end else begin
            acc_count++;
        end
    endtask

    task automatic predict_item(input logic func, input logic rising, input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] thr;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       five_periods;
        logic              done;
        logic [BYTE_W-1:0] byte_out;
        done     = 1'b0;
        byte_out = '0;
        if (func == FUNC_IDLE) begin
            elapsed      = t - active_stamp;
            five_periods = 64'(period) * 5;
            if (period != 0 && period <= STAMP_MAX / 5 && 64'(elapsed) > five_periods) begin
                clear_framing();
            end
        end else begin
            if (first_wait) begin
                first_wait  = 1'b0;
                start_stamp = t;
            end else if (period == 0) begin
                period = t - start_stamp;
            end
            gap = t - edge_stamp;
            thr = two_thirds_of(period);
            if (sync_wait && last_gap != 0) begin
                if (gap > thr) begin
                    shift_in(last_dir, done, byte_out);
                end
                shift_in(rising, done, byte_out);
                data_edge = 1'b1;
                sync_wait = 1'b0;
            end else if (data_edge) begin
                if (gap > thr) begin
                    shift_in(rising, done, byte_out);
                end else begin
                    data_edge = 1'b0;
                end
            end else if (gap < thr) begin
                shift_in(rising, done, byte_out);
                data_edge = 1'b1;
            end
            last_dir     = rising;
            last_gap     = gap;
            edge_stamp   = t;
            active_stamp = t;
            if (done) begin
                expected_bytes.push_back(byte_out);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            first_wait   = 1'b1;
            start_stamp  = '0;
            period       = '0;
            last_dir     = 1'b0;
            active_stamp = '0;
            clear_framing();
            expected_bytes.delete();
            pending = 0;
        end else begin
            // result side first: a byte leaving now belongs to an earlier transfer
            if (m_tvalid && m_tready) begin
                results++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h", m_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("data_byte %02h, want %02h", m_tdata, want));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_item(s_tuser, s_tdata[RISING_LSB], s_tdata[TIME_LSB +: TIME_W]);
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ----- verif/manchester_edge_decoder_top_tb.sv -----
// ----------------------------------------------------------------------------
// manchester edge decoder testbench
// drives timestamped edges and idle checks: a directed opening around period
// learning, threshold ties and idle timeouts, then random manchester frames
// mixed with noise edges, under changing sender gaps and receiver stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module manchester_edge_decoder_top_tb;
    import med_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 340;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum int {PH_FREE, PH_SRC_IDLE, PH_SNK_STALL, PH_BOTH, PH_HOLD} phase_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;

    int errors;
    int pending;
    int results;

    phase_t            phase = PH_FREE;
    int                items_sent = 0;
    int                idle_sent = 0;
    int                hold_left = 0;
    bit                hold_served = 0;
    int                cycle_count = 0;
    int                random_base;
    int                pick;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] thr;
    logic [TIME_W-1:0] tb_now = '0;
    logic              line = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    manchester_edge_decoder_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    manchester_edge_decoder_checker u_chk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .errors  (errors),
        .pending (pending),
        .results (results)
    );

    function automatic int idle_pct(input phase_t p);
        case (p)
            PH_SRC_IDLE: return 81;
            PH_BOTH:     return 6;
            default:     return 0;
        endcase
    endfunction

    function automatic int stall_pct(input phase_t p);
        case (p)
            PH_SNK_STALL: return 81;
            PH_BOTH:      return 6;
            default:      return 0;
        endcase
    endfunction

    // receiver side, with one long hold-off counted here
    always @(posedge aclk) begin
        if (phase == PH_HOLD && !hold_served) begin
            hold_served = 1;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct(phase));
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count, pending);
        $display("manchester_edge_decoder_top_tb: done, errors");
        $finish;
    end

    function automatic logic [TIME_W-1:0] jitter(input logic [TIME_W-1:0] base);
        logic [TIME_W-1:0] j;
        j = period / 10;
        return base + $urandom_range(2 * j) - j;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom());
        endcase
    endfunction

    task automatic send_item(input logic f, input logic r, input logic [TIME_W-1:0] t);
        logic [S_TDATA_W-1:0] word;
        word                     = '0;
        word[RISING_LSB]         = r;
        word[TIME_LSB +: TIME_W] = t;
        while ($urandom_range(99) < idle_pct(phase)) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_edge(input logic r, input logic [TIME_W-1:0] t);
        send_item(FUNC_EDGE, r, t);
        tb_now = t;
        line   = r;
    endtask

    task automatic send_idle(input logic [TIME_W-1:0] t);
        send_item(FUNC_IDLE, 1'($urandom_range(1)), t);
        idle_sent++;
    endtask

    task automatic send_clear();
        send_idle(tb_now + 5 * period + 1 + $urandom_range(5 * period));
    endtask

    task automatic send_lead();
        send_edge(!line, tb_now + $urandom());
    endtask

    // mid-bit edge carries the bit; a boundary edge comes first when the line
    // already sits at the bit's level
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        for (int i = 0; i < BYTE_W; i++) begin
            if (line == b[i]) begin
                send_edge(!line, tb_now + jitter(period / 2));
                send_edge(b[i], tb_now + jitter(period / 2));
            end else begin
                send_edge(b[i], tb_now + jitter(period));
            end
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) begin
            if ($urandom_range(3) == 0) begin
                send_edge(1'($urandom_range(1)), $urandom());
            end else begin
                send_edge(1'($urandom_range(1)), tb_now + $urandom_range(2 * period));
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening
        period = $urandom_range(300, 3000);
        thr    = (2 * period) / 3;
        send_idle($urandom());                 // no period yet, no effect
        send_edge(1'b1, 32'hFFFF_FF00);        // first edge, gap is the raw stamp
        send_edge(1'b0, 32'hFFFF_FF00);        // zero gap keeps the period unlearned
        send_edge(1'b1, 32'hFFFF_FF00 + period); // wraps, period learned here
        send_edge(1'b0, tb_now + period);
        send_edge(1'b1, tb_now + thr);         // tie with threshold on a data edge
        send_edge(1'b0, tb_now + thr);         // tie with threshold off a data edge
        send_edge(1'b1, tb_now + thr - 1);
        send_idle(tb_now + 5 * period);        // exactly five periods, kept
        send_idle(tb_now + 5 * period + 1);    // just past five periods, cleared
        send_lead();
        send_byte(8'h55);
        send_idle(tb_now - 1);                 // largest elapsed time

        // long receiver hold while the sender keeps going
        phase = PH_HOLD;
        send_clear();
        send_lead();
        repeat (3) send_byte(pick_byte());
        phase = PH_FREE;
        wait_drained();

        random_base = items_sent;
        while (items_sent < random_base + RANDOM_ITEMS) begin
            phase = phase_t'(((items_sent - random_base) / (RANDOM_ITEMS / 4)) % 4);
            pick  = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(1)) begin
                    send_clear();
                    send_lead();
                end
                repeat ($urandom_range(1, 3)) send_byte(pick_byte());
            end else if (pick < 85) begin
                send_noise($urandom_range(1, 6));
            end else if ($urandom_range(1)) begin
                send_idle(tb_now + $urandom_range(10 * period));
            end else begin
                send_idle($urandom());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d transfers in (%0d idle checks), %0d bytes out, bit period %0d",
                 items_sent, idle_sent, results, period);
        $display("ran free flow, sender gaps, receiver stalls, both, and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (errors == 0 && pending == 0) begin
            $display("manchester_edge_decoder_top_tb: done, clean");
        end else begin
            $display("manchester_edge_decoder_top_tb: done, errors");
        end
        $finish;
    end

endmodule
